### sv/fupa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_pkg
// Shared types, widths, codes and helper functions of the fixed unit pool
// allocator.
// ----------------------------------------------------------------------------
package fupa_pkg;

    localparam int MAX_CHUNKS = 8;
    localparam int UNITS_MAX  = 256;
    localparam int CHUNK_W    = $clog2(MAX_CHUNKS);
    localparam int UNIT_W     = $clog2(UNITS_MAX);
    localparam int CNT_W      = UNIT_W + 1;
    localparam int ACT_W      = CHUNK_W + 1;
    localparam int LINK_DEPTH = MAX_CHUNKS * UNITS_MAX;
    localparam int LINK_AW    = CHUNK_W + UNIT_W;
    localparam int SIZE_W     = 9;
    localparam int BYTES_W    = 13;
    localparam int OFFSET_W   = 20;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [SIZE_W-1:0]  FIRST_UNITS_RST = SIZE_W'(64);
    localparam logic [SIZE_W-1:0]  GROW_UNITS_RST  = SIZE_W'(64);
    localparam logic [BYTES_W-1:0] UNIT_BYTES_RST  = BYTES_W'(64);
    localparam logic [BYTES_W-1:0] BYTES_MIN       = BYTES_W'(2);
    localparam logic [BYTES_W-1:0] BYTES_MAX       = BYTES_W'(4096);

    typedef enum logic [1:0] {
        REG_FIRST_UNITS = 2'd0,
        REG_GROW_UNITS  = 2'd1,
        REG_UNIT_BYTES  = 2'd2
    } reg_idx_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_FREED      = 2'd1,
        ST_OUT_OF_MEM = 2'd2,
        ST_FOREIGN    = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [CHUNK_W-1:0] free_chunk;
        logic [UNIT_W-1:0]  free_unit;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [CHUNK_W-1:0]  out_chunk;
        logic [UNIT_W-1:0]   out_unit;
        logic [OFFSET_W-1:0] byte_offset;
        logic                chunk_grown;
        logic                chunk_released;
    } result_t;

    function automatic logic [SIZE_W-1:0] clamp_units(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > SIZE_W'(UNITS_MAX))
        begin
            r = SIZE_W'(UNITS_MAX);
        end
        return r;
    endfunction

    function automatic logic [BYTES_W-1:0] clamp_bytes(input logic [BYTES_W-1:0] v);
        logic [BYTES_W-1:0] r;
        r = v;
        if (v < BYTES_MIN)
        begin
            r = BYTES_MIN;
        end
        else if (v > BYTES_MAX)
        begin
            r = BYTES_MAX;
        end
        return r;
    endfunction

endpackage

### sv/fupa_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_item_if / fupa_result_if
// Valid/ready channels that carry request items into the allocator and
// result items out of it.
// ----------------------------------------------------------------------------
interface fupa_item_if;
    logic            valid;
    logic            ready;
    fupa_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fupa_result_if;
    logic              valid;
    logic              ready;
    fupa_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/fupa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fupa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/fixed_unit_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_unit_pool_allocator
// Hands out and takes back fixed-size units from a stack of up to eight
// chunks, keeping the free lists of all chunks in one link RAM.
//
// Channel     | Dir | Handshake      | Payload
// ------------+-----+----------------+------------------------------------
// item_in     | in  | valid / ready  | op, free_chunk, free_unit
// result_out  | out | valid / ready  | status, out_chunk, out_unit,
//             |     |                | byte_offset, chunk_grown,
//             |     |                | chunk_released
// APB         | in  | psel / penable | first_units, grow_units, unit_bytes
//
// A free or a failing request goes from the idle state straight to the
// response state; an allocation from an existing chunk passes the link
// state between them, for the registered read data of the link RAM. An
// allocation that pushes a chunk first writes the new chunk's links into the RAM, one link a cycle.
// After reset, and after a write of first_units or grow_units, chunk 0 is
// relinked in the fill state, during which no item is accepted.
// A result waits in the output register while result_out stalls; the next
// item is accepted meanwhile.
// ----------------------------------------------------------------------------
module fixed_unit_pool_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    fupa_item_if.sink                     item_in,
    fupa_result_if.source                 result_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fupa_pkg::APB_AW-1:0]   paddr,
    input  logic [fupa_pkg::APB_DW-1:0]   pwdata,
    output logic [fupa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_LINK,
        S_RESP
    } state_t;

    typedef logic [fupa_pkg::CNT_W-1:0]   cnt_t;
    typedef logic [fupa_pkg::UNIT_W-1:0]  unit_t;
    typedef logic [fupa_pkg::CHUNK_W-1:0] chunk_t;
    typedef logic [fupa_pkg::ACT_W-1:0]   act_t;

    state_t                        state_reg, state_next;
    logic [fupa_pkg::SIZE_W-1:0]   first_units_reg, first_units_next;
    logic [fupa_pkg::SIZE_W-1:0]   grow_units_reg, grow_units_next;
    logic [fupa_pkg::BYTES_W-1:0]  unit_bytes_reg, unit_bytes_next;
    cnt_t                          count_reg [fupa_pkg::MAX_CHUNKS];
    cnt_t                          count_next [fupa_pkg::MAX_CHUNKS];
    unit_t                         head_reg [fupa_pkg::MAX_CHUNKS];
    unit_t                         head_next [fupa_pkg::MAX_CHUNKS];
    act_t                          active_reg, active_next;
    chunk_t                        fill_slot_reg, fill_slot_next;
    unit_t                         fill_idx_reg, fill_idx_next;
    unit_t                         fill_last_reg, fill_last_next;
    logic                          fill_resp_reg, fill_resp_next;
    fupa_pkg::status_t             res_status_reg, res_status_next;
    chunk_t                        res_chunk_reg, res_chunk_next;
    unit_t                         res_unit_reg, res_unit_next;
    logic                          res_grown_reg, res_grown_next;
    logic                          res_released_reg, res_released_next;
    fupa_pkg::result_t             out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          ram_we;
    logic [fupa_pkg::LINK_AW-1:0]  ram_waddr;
    unit_t                         ram_wdata;
    logic [fupa_pkg::LINK_AW-1:0]  ram_raddr;
    unit_t                         ram_rdata;

    logic                          cfg_wr;
    fupa_pkg::reg_idx_t            cfg_idx;
    logic [fupa_pkg::SIZE_W-1:0]   first_size;
    logic [fupa_pkg::SIZE_W-1:0]   grow_size;
    logic [fupa_pkg::SIZE_W-1:0]   init_size;
    logic [fupa_pkg::BYTES_W-1:0]  eff_bytes;
    logic [fupa_pkg::UNIT_W+fupa_pkg::BYTES_W-1:0] offset_full;
    logic                          accept;
    logic                          hit;
    chunk_t                        pick;
    chunk_t                        fc;
    unit_t                         fu;
    logic [fupa_pkg::SIZE_W-1:0]   fsize;
    cnt_t                          count_inc;
    logic                          free_ok;
    logic                          release_top;
    chunk_t                        new_slot;

    fupa_ram #(
        .WIDTH (fupa_pkg::UNIT_W),
        .DEPTH (fupa_pkg::LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_wr     = psel & penable & pwrite;
    assign cfg_idx    = fupa_pkg::reg_idx_t'(paddr[fupa_pkg::APB_AW-1:2]);
    assign pready     = 1'b1;
    assign first_size = fupa_pkg::clamp_units(first_units_reg);
    assign grow_size  = fupa_pkg::clamp_units(grow_units_reg);
    assign eff_bytes  = fupa_pkg::clamp_bytes(unit_bytes_reg);
    assign offset_full = {{fupa_pkg::BYTES_W{1'b0}}, res_unit_reg}
                       * {{fupa_pkg::UNIT_W{1'b0}}, eff_bytes};

    assign item_in.ready   = (state_reg == S_IDLE);
    assign accept          = item_in.valid & item_in.ready;
    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_reg;

    always_comb
    begin
        case (cfg_idx)
            fupa_pkg::REG_FIRST_UNITS: prdata = fupa_pkg::APB_DW'(first_units_reg);
            fupa_pkg::REG_GROW_UNITS:  prdata = fupa_pkg::APB_DW'(grow_units_reg);
            fupa_pkg::REG_UNIT_BYTES:  prdata = fupa_pkg::APB_DW'(unit_bytes_reg);
            default:                   prdata = '0;
        endcase
    end

    always_comb
    begin
        hit  = 1'b0;
        pick = '0;
        for (int i = 0; i < fupa_pkg::MAX_CHUNKS; i++)
        begin
            if ((act_t'(i) < active_reg) && (count_reg[i] != '0))
            begin
                hit  = 1'b1;
                pick = chunk_t'(i);
            end
        end
    end

    assign fc        = item_in.data.free_chunk;
    assign fu        = item_in.data.free_unit;
    assign fsize     = (fc == '0) ? first_size : grow_size;
    assign count_inc = count_reg[fc] + cnt_t'(1);
    assign free_ok   = ({1'b0, fc} < active_reg)
                     && (fupa_pkg::SIZE_W'(fu) < fsize)
                     && (fupa_pkg::SIZE_W'(count_reg[fc]) < fsize);
    assign release_top = (fupa_pkg::SIZE_W'(count_inc) == fsize)
                       && ({1'b0, fc} == act_t'(active_reg - act_t'(1)))
                       && (active_reg > act_t'(1));
    assign new_slot  = active_reg[fupa_pkg::CHUNK_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        first_units_next  = first_units_reg;
        grow_units_next   = grow_units_reg;
        unit_bytes_next   = unit_bytes_reg;
        count_next        = count_reg;
        head_next         = head_reg;
        active_next       = active_reg;
        fill_slot_next    = fill_slot_reg;
        fill_idx_next     = fill_idx_reg;
        fill_last_next    = fill_last_reg;
        fill_resp_next    = fill_resp_reg;
        res_status_next   = res_status_reg;
        res_chunk_next    = res_chunk_reg;
        res_unit_next     = res_unit_reg;
        res_grown_next    = res_grown_reg;
        res_released_next = res_released_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = '0;
        ram_raddr         = '0;
        init_size         = first_size;

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = {fill_slot_reg, fill_idx_reg};
                ram_wdata = fill_idx_reg + unit_t'(1);
                fill_idx_next = fill_idx_reg + unit_t'(1);
                if (fill_idx_reg == fill_last_reg)
                begin
                    state_next = fill_resp_reg ? S_RESP : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_chunk_next    = '0;
                    res_unit_next     = '0;
                    res_grown_next    = 1'b0;
                    res_released_next = 1'b0;
                    state_next        = S_RESP;
                    if (item_in.data.op == fupa_pkg::OP_ALLOC)
                    begin
                        if (hit)
                        begin
                            ram_raddr         = {pick, head_reg[pick]};
                            count_next[pick]  = count_reg[pick] - cnt_t'(1);
                            res_status_next   = fupa_pkg::ST_ALLOCATED;
                            res_chunk_next    = pick;
                            res_unit_next     = head_reg[pick];
                            state_next        = S_LINK;
                        end
                        else if (active_reg < act_t'(fupa_pkg::MAX_CHUNKS))
                        begin
                            count_next[new_slot] = cnt_t'(grow_size - fupa_pkg::SIZE_W'(1));
                            head_next[new_slot]  = (grow_size > fupa_pkg::SIZE_W'(1))
                                                 ? unit_t'(1) : unit_t'(0);
                            active_next     = active_reg + act_t'(1);
                            res_status_next = fupa_pkg::ST_ALLOCATED;
                            res_chunk_next  = new_slot;
                            res_grown_next  = 1'b1;
                            if (grow_size > fupa_pkg::SIZE_W'(1))
                            begin
                                fill_slot_next = new_slot;
                                fill_idx_next  = unit_t'(1);
                                fill_last_next = unit_t'(grow_size - fupa_pkg::SIZE_W'(1));
                                fill_resp_next = 1'b1;
                                state_next     = S_FILL;
                            end
                        end
                        else
                        begin
                            res_status_next = fupa_pkg::ST_OUT_OF_MEM;
                        end
                    end
                    else
                    begin
                        if (free_ok)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = {fc, fu};
                            ram_wdata       = head_reg[fc];
                            count_next[fc]  = count_inc;
                            head_next[fc]   = fu;
                            res_status_next = fupa_pkg::ST_FREED;
                            if (release_top)
                            begin
                                count_next[fc]    = '0;
                                head_next[fc]     = '0;
                                active_next       = active_reg - act_t'(1);
                                res_released_next = 1'b1;
                            end
                        end
                        else
                        begin
                            res_status_next = fupa_pkg::ST_FOREIGN;
                        end
                    end
                end
            end

            S_LINK:
            begin
                if (count_reg[res_chunk_reg] != '0)
                begin
                    head_next[res_chunk_reg] = ram_rdata;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_next.status         = res_status_reg;
                    out_next.out_chunk      = res_chunk_reg;
                    out_next.out_unit       = res_unit_reg;
                    out_next.byte_offset    = offset_full[fupa_pkg::OFFSET_W-1:0];
                    out_next.chunk_grown    = res_grown_reg;
                    out_next.chunk_released = res_released_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr && (cfg_idx == fupa_pkg::REG_UNIT_BYTES))
        begin
            unit_bytes_next = pwdata[fupa_pkg::BYTES_W-1:0];
        end

        if (cfg_wr && ((cfg_idx == fupa_pkg::REG_FIRST_UNITS)
                       || (cfg_idx == fupa_pkg::REG_GROW_UNITS)))
        begin
            if (cfg_idx == fupa_pkg::REG_FIRST_UNITS)
            begin
                first_units_next = pwdata[fupa_pkg::SIZE_W-1:0];
                init_size = fupa_pkg::clamp_units(pwdata[fupa_pkg::SIZE_W-1:0]);
            end
            else
            begin
                grow_units_next = pwdata[fupa_pkg::SIZE_W-1:0];
            end
            for (int i = 0; i < fupa_pkg::MAX_CHUNKS; i++)
            begin
                count_next[i] = '0;
                head_next[i]  = '0;
            end
            count_next[0]  = cnt_t'(init_size);
            active_next    = act_t'(1);
            fill_slot_next = '0;
            fill_idx_next  = '0;
            fill_last_next = unit_t'(init_size - fupa_pkg::SIZE_W'(1));
            fill_resp_next = 1'b0;
            state_next     = S_FILL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FILL;
            first_units_reg  <= fupa_pkg::FIRST_UNITS_RST;
            grow_units_reg   <= fupa_pkg::GROW_UNITS_RST;
            unit_bytes_reg   <= fupa_pkg::UNIT_BYTES_RST;
            for (int i = 0; i < fupa_pkg::MAX_CHUNKS; i++)
            begin
                if (i == 0)
                begin
                    count_reg[i] <= cnt_t'(fupa_pkg::FIRST_UNITS_RST);
                end
                else
                begin
                    count_reg[i] <= '0;
                end
                head_reg[i]  <= '0;
            end
            active_reg       <= act_t'(1);
            fill_slot_reg    <= '0;
            fill_idx_reg     <= '0;
            fill_last_reg    <= unit_t'(fupa_pkg::FIRST_UNITS_RST - fupa_pkg::SIZE_W'(1));
            fill_resp_reg    <= 1'b0;
            res_status_reg   <= fupa_pkg::ST_ALLOCATED;
            res_chunk_reg    <= '0;
            res_unit_reg     <= '0;
            res_grown_reg    <= 1'b0;
            res_released_reg <= 1'b0;
            out_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_units_reg  <= first_units_next;
            grow_units_reg   <= grow_units_next;
            unit_bytes_reg   <= unit_bytes_next;
            count_reg        <= count_next;
            head_reg         <= head_next;
            active_reg       <= active_next;
            fill_slot_reg    <= fill_slot_next;
            fill_idx_reg     <= fill_idx_next;
            fill_last_reg    <= fill_last_next;
            fill_resp_reg    <= fill_resp_next;
            res_status_reg   <= res_status_next;
            res_chunk_reg    <= res_chunk_next;
            res_unit_reg     <= res_unit_next;
            res_grown_reg    <= res_grown_next;
            res_released_reg <= res_released_next;
            out_reg          <= out_next;
            out_valid_reg    <= out_valid_next;
        end
    end

endmodule

### sv/fupa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fupa_port_checker
// Port-level checks on the allocator's request and result channels, bound
// to the top level.
// ----------------------------------------------------------------------------
module fupa_port_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input fupa_pkg::status_t               out_status,
    input logic [fupa_pkg::CHUNK_W-1:0]    out_chunk,
    input logic [fupa_pkg::UNIT_W-1:0]     out_unit,
    input logic [fupa_pkg::OFFSET_W-1:0]   out_offset,
    input logic                            out_grown,
    input logic                            out_released
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result item withdrawn before it was taken.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second item was offered acceptance while one is in work.");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != fupa_pkg::ST_ALLOCATED)
        |-> (out_chunk == '0) && (out_unit == '0) && (out_offset == '0) && !out_grown)
        else $error("A result without an allocation carries a handle.");

    a_grown_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_grown
        |-> (out_status == fupa_pkg::ST_ALLOCATED) && (out_unit == '0)
            && (out_offset == '0) && (out_chunk != '0))
        else $error("A pushed chunk did not hand out its first unit.");

    a_released_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_released |-> (out_status == fupa_pkg::ST_FREED))
        else $error("A chunk was released by something other than a free.");

endmodule

bind fixed_unit_pool_allocator fupa_port_checker u_fupa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item_in.valid),
    .in_ready     (item_in.ready),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_status   (result_out.data.status),
    .out_chunk    (result_out.data.out_chunk),
    .out_unit     (result_out.data.out_unit),
    .out_offset   (result_out.data.byte_offset),
    .out_grown    (result_out.data.chunk_grown),
    .out_released (result_out.data.chunk_released)
);
